### rtl/audio_linear_fade_in_defines.svh
// Assertion macros for the fade-in block. They sample on clk and are
// disabled while arst_n is low.
`ifndef AUDIO_LINEAR_FADE_IN_DEFINES_SVH
`define AUDIO_LINEAR_FADE_IN_DEFINES_SVH

// Same-cycle implication
`define ALFI_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fade-in check failed");

// Next-cycle implication
`define ALFI_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fade-in check failed");

`endif

### rtl/alfi_pkg.sv
package alfi_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int CFG_DATA_W = 4;
	localparam int CFG_IDX_W  = 2;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHANNEL_COUNT     = 2'd0,
		CFG_SAMPLE_WIDTH_MODE = 2'd1
	} cfg_idx_t;

	// sample width modes
	localparam logic MODE_16 = 1'b0;
	localparam logic MODE_32 = 1'b1;

	localparam logic [CFG_DATA_W-1:0] CHANNEL_COUNT_RST = 4'd2;

	// gain is held as a fraction with this many bits below the point
	localparam int GAIN_FRAC_W = 32;
	localparam int GAIN_W      = GAIN_FRAC_W + 1;

endpackage

### rtl/alfi_in_if.sv
interface alfi_in_if;
	logic                                valid;
	logic                                ready;
	logic                                start_fade;
	logic signed [alfi_pkg::SAMPLE_W-1:0] sample_in;

	modport source (output valid, start_fade, sample_in, input ready);
	modport sink   (input valid, start_fade, sample_in, output ready);
endinterface

### rtl/alfi_out_if.sv
interface alfi_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [alfi_pkg::SAMPLE_W-1:0] sample_out;
	logic                                fade_active;

	modport source (output valid, sample_out, fade_active, input ready);
	modport sink   (input valid, sample_out, fade_active, output ready);
endinterface

### rtl/audio_linear_fade_in.sv
// Linear fade-in for an interleaved integer PCM stream.
// in_ch carries one sample per item with a start_fade flag; a set flag marks
// the first channel of a frame and starts a fade of FADE_FRAMES frames.
// out_ch returns one item per input item, in order: the faded sample and
// fade_active, set while the frame gain k/FADE_FRAMES is below unity.
// Both channels are valid/ready; an item moves when both are high.
// Configuration (channel count, 16/32-bit mode) is written through cfg_we/cfg_index/
// cfg_data; the user must write it only while no item is in flight (not enforced).
// A result passes the input register, two multiplier stages and the correction
// into the output register. Throughput: one item per clock through the
// four-stage pipeline while out_ch.ready is high; the frame gain is kept
// as an exact running fraction so no stage divides.
// A stalled receiver holds the output register; upstream stages keep filling
// any empty slot behind it, so in_ch.ready only drops once all four stages
// are full.
// Reset clears the pipeline, ends any fade (samples pass unchanged), sets
// two channels and 16-bit mode.
`include "audio_linear_fade_in_defines.svh"

module audio_linear_fade_in #(
	parameter int FADE_FRAMES  = 256,
	parameter int MAX_CHANNELS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	alfi_in_if.sink                              in_ch,
	alfi_out_if.source                           out_ch,
	input  logic                                 cfg_we,
	input  logic [alfi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [alfi_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int SW      = alfi_pkg::SAMPLE_W;
	localparam int GW      = alfi_pkg::GAIN_W;
	localparam int FW      = alfi_pkg::GAIN_FRAC_W;
	localparam int LEFT_W  = $clog2(FADE_FRAMES + 1);
	localparam int POS_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_W   = ($clog2(MAX_CHANNELS + 1) > alfi_pkg::CFG_DATA_W) ?
	                         $clog2(MAX_CHANNELS + 1) : alfi_pkg::CFG_DATA_W;
	localparam int PROD_W  = SW + LEFT_W;
	localparam int AG_W    = SW + GW;

	// gain of frame k is floor(k * 2^32 / F) plus a remainder below F
	localparam logic [GW-1:0]     GAIN_STEP     = GW'((64'd1 << FW) / FADE_FRAMES);
	localparam logic [LEFT_W-1:0] GAIN_STEP_REM = LEFT_W'((64'd1 << FW) % FADE_FRAMES);
	localparam logic [LEFT_W-1:0] FRAMES        = LEFT_W'(FADE_FRAMES);
	localparam logic [LEFT_W-1:0] FRAMES_M1     = LEFT_W'(FADE_FRAMES - 1);
	localparam logic [LEFT_W-1:0] FRAMES_P1     = LEFT_W'(FADE_FRAMES + 1);
	localparam logic [LEFT_W:0]   FRAMES_X      = (LEFT_W + 1)'(FADE_FRAMES);
	localparam logic [PROD_W-1:0] FRAMES_P      = PROD_W'(FADE_FRAMES);
	localparam logic [PROD_W-1:0] TWO_FRAMES    = PROD_W'(2 * FADE_FRAMES);
	localparam logic [CNT_W-1:0]  MAX_CH        = CNT_W'(MAX_CHANNELS);

	// configuration registers
	logic [alfi_pkg::CFG_DATA_W-1:0] chan_cnt_q;
	logic                            mode_q;

	// fade state
	logic [LEFT_W-1:0] left_q;
	logic [POS_W-1:0]  pos_q;
	logic [GW-1:0]     gain_q;
	logic [LEFT_W-1:0] grem_q;

	// handshake
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic accept;

	// front-end combinational signals
	logic [CNT_W-1:0]  cnt_ext, eff_cnt;
	logic [LEFT_W-1:0] left_cur, k_cur;
	logic [POS_W-1:0]  pos_cur;
	logic [GW-1:0]     gain_cur;
	logic [LEFT_W-1:0] grem_cur;
	logic [LEFT_W:0]   grem_sum;
	logic              frame_end, fading, gain_below_unity;
	logic [SW-1:0]     samp_ext, samp_mag;

	// stage 1: captured item
	logic [SW-1:0]     samp_s1, mag_s1;
	logic              neg_s1, fade_s1, act_s1;
	logic [LEFT_W-1:0] k_s1;
	logic [GW-1:0]     gain_s1;

	// stage 2: products
	logic [AG_W-1:0]   ag_prod;
	logic [SW-1:0]     samp_s2, y_s2;
	logic [PROD_W-1:0] ak_s2;
	logic              neg_s2, fade_s2, act_s2;

	// stage 3: quotient estimate and its back-product
	logic [SW-1:0]     samp_s3, y_s3;
	logic [PROD_W-1:0] ak_s3, yf_s3;
	logic              neg_s3, fade_s3, act_s3;

	// output stage
	logic [PROD_W-1:0] rem_s3;
	logic [SW-1:0]     q_s3, res_s3;
	logic [SW-1:0]     out_s4;
	logic              act_s4;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q <= alfi_pkg::CHANNEL_COUNT_RST;
			mode_q     <= alfi_pkg::MODE_16;
		end else if (cfg_we) begin
			// indexes past the register list are dropped
			if (cfg_index == alfi_pkg::CFG_CHANNEL_COUNT) begin
				chan_cnt_q <= cfg_data;
			end else if (cfg_index == alfi_pkg::CFG_SAMPLE_WIDTH_MODE) begin
				mode_q <= cfg_data[0];
			end
		end
	end

	// ---------------- handshake ----------------
	// Each stage takes a new item when it is empty or its content moves on.
	assign rdy_s4      = !vld_s4 || out_ch.ready;
	assign rdy_s3      = !vld_s3 || rdy_s4;
	assign rdy_s2      = !vld_s2 || rdy_s3;
	assign rdy_s1      = !vld_s1 || rdy_s2;
	assign in_ch.ready = rdy_s1;
	assign accept      = in_ch.valid && rdy_s1;

	// ---------------- frame tracking and gain ----------------
	always_comb begin
		// zero channels act as one, too many clamp to the maximum
		cnt_ext = CNT_W'(chan_cnt_q);
		if (cnt_ext == '0) begin
			eff_cnt = CNT_W'(1);
		end else if (cnt_ext > MAX_CH) begin
			eff_cnt = MAX_CH;
		end else begin
			eff_cnt = cnt_ext;
		end

		// a start flag reloads the fade and restarts the frame
		if (in_ch.start_fade) begin
			left_cur = FRAMES;
			pos_cur  = '0;
			gain_cur = GAIN_STEP;
			grem_cur = GAIN_STEP_REM;
		end else begin
			left_cur = left_q;
			pos_cur  = pos_q;
			gain_cur = gain_q;
			grem_cur = grem_q;
		end

		fading           = (left_cur != '0);
		gain_below_unity = (left_cur > LEFT_W'(1));
		k_cur            = FRAMES_P1 - left_cur;
		// a position left past a shrunken count also ends the frame
		frame_end        = ((CNT_W'(pos_cur) + CNT_W'(1)) >= eff_cnt);
		grem_sum         = {1'b0, grem_cur} + {1'b0, GAIN_STEP_REM};

		if (mode_q == alfi_pkg::MODE_32) begin
			samp_ext = in_ch.sample_in;
		end else begin
			samp_ext = {{(SW - 16){in_ch.sample_in[15]}}, in_ch.sample_in[15:0]};
		end
		samp_mag = samp_ext[SW-1] ? (~samp_ext + SW'(1)) : samp_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			pos_q  <= '0;
			gain_q <= '0;
			grem_q <= '0;
		end else if (accept) begin
			pos_q <= frame_end ? '0 : (pos_cur + POS_W'(1));
			if (frame_end && fading) begin
				// advance to the next frame's gain, carrying the remainder
				left_q <= left_cur - LEFT_W'(1);
				if (grem_sum >= FRAMES_X) begin
					grem_q <= LEFT_W'(grem_sum - FRAMES_X);
					gain_q <= gain_cur + GAIN_STEP + GW'(1);
				end else begin
					grem_q <= grem_sum[LEFT_W-1:0];
					gain_q <= gain_cur + GAIN_STEP;
				end
			end else begin
				left_q <= left_cur;
				gain_q <= gain_cur;
				grem_q <= grem_cur;
			end
		end
	end

	// ---------------- pipeline valids ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_ch.valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	// ---------------- stage 1: capture ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			samp_s1 <= samp_ext;
			mag_s1  <= samp_mag;
			neg_s1  <= samp_ext[SW-1];
			fade_s1 <= fading;
			act_s1  <= fading && gain_below_unity;
			k_s1    <= k_cur;
			gain_s1 <= gain_cur;
		end
	end

	// ---------------- stage 2: |s| * gain and |s| * k ----------------
	assign ag_prod = AG_W'(mag_s1) * AG_W'(gain_s1);

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			samp_s2 <= samp_s1;
			neg_s2  <= neg_s1;
			fade_s2 <= fade_s1;
			act_s2  <= act_s1;
			// estimate is floor(|s| * k / F) or one below it
			y_s2    <= ag_prod[FW +: SW];
			ak_s2   <= PROD_W'(mag_s1) * PROD_W'(k_s1);
		end
	end

	// ---------------- stage 3: estimate * F ----------------
	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			samp_s3 <= samp_s2;
			neg_s3  <= neg_s2;
			fade_s3 <= fade_s2;
			act_s3  <= act_s2;
			y_s3    <= y_s2;
			ak_s3   <= ak_s2;
			yf_s3   <= PROD_W'(y_s2) * FRAMES_P;
		end
	end

	// ---------------- output: correct, restore sign ----------------
	always_comb begin
		rem_s3 = ak_s3 - yf_s3;
		q_s3   = y_s3 + SW'(rem_s3 >= FRAMES_P);
		res_s3 = neg_s3 ? (~q_s3 + SW'(1)) : q_s3;
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			// outside a fade the sample passes unchanged
			out_s4 <= fade_s3 ? res_s3 : samp_s3;
			act_s4 <= act_s3;
		end
	end

	assign out_ch.valid       = vld_s4;
	assign out_ch.sample_out  = out_s4;
	assign out_ch.fade_active = act_s4;

	// ---------------- checks ----------------
	`ALFI_ASSERT_IMP(a_quot_err_bound, vld_s3 && fade_s3, rem_s3 < TWO_FRAMES)
	`ALFI_ASSERT_NXT(a_start_loads, accept && in_ch.start_fade, left_q >= FRAMES_M1)
	`ALFI_ASSERT_IMP(a_pos_bound, 1'b1, CNT_W'(pos_q) < MAX_CH)

endmodule

### dv/tb_audio_linear_fade_in.sv
`timescale 1ns / 1ps

module tb_audio_linear_fade_in;

	localparam int SAMPLE_W   = alfi_pkg::SAMPLE_W;
	localparam int CFG_IDX_W  = alfi_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = alfi_pkg::CFG_DATA_W;

	localparam int FADE_LEN   = 256;
	localparam int MAX_CH     = 8;
	// four-stage pipeline between acceptance and a valid result
	localparam int PIPE_DEPTH = 4;
	localparam int CYCLE_CAP  = 400000;
	localparam int RAND_ITEMS = 700;

	// indexes past the last register: writes to them must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       active;
	} faded_sample_t;

	// Tracks the fade state of the stream, works out the faded sample for
	// every accepted item and matches results against them in order.
	class fade_ramp_tracker;
		logic [CFG_DATA_W-1:0] chans;
		logic                  width_mode;
		logic [8:0]            frames_left;
		logic [2:0]            chan_pos;
		faded_sample_t         faded_due[$];
		int unsigned           mismatches;
		int unsigned           matched;

		function new();
			chans       = alfi_pkg::CHANNEL_COUNT_RST;
			width_mode  = alfi_pkg::MODE_16;
			frames_left = '0;
			chan_pos    = '0;
			mismatches  = 0;
			matched     = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				alfi_pkg::CFG_CHANNEL_COUNT:     chans = data;
				alfi_pkg::CFG_SAMPLE_WIDTH_MODE: width_mode = data[0];
				default: ;
			endcase
		endfunction

		function int unsigned position();
			return chan_pos;
		endfunction

		function int unsigned waiting();
			return faded_due.size();
		endfunction

		function faded_sample_t fade_sample(bit start, logic [SAMPLE_W-1:0] raw);
			faded_sample_t res;
			int            nch;
			longint        s;
			longint        r;
			longint        k;
			nch = (chans == 0) ? 1 : ((chans > MAX_CH) ? MAX_CH : int'(chans));
			if (start) begin
				frames_left = 9'(FADE_LEN);
				chan_pos    = '0;
			end
			if (width_mode == alfi_pkg::MODE_32)
				s = longint'(signed'(raw));
			else
				s = longint'(signed'(raw[15:0]));
			r          = s;
			res.active = 1'b0;
			if (frames_left != 0) begin
				k          = longint'(FADE_LEN) - longint'(frames_left) + 1;
				// signed division truncates toward zero
				r          = (s * k) / longint'(FADE_LEN);
				res.active = (k < FADE_LEN);
			end
			if (int'(chan_pos) + 1 >= nch) begin
				chan_pos = '0;
				if (frames_left != 0)
					frames_left = frames_left - 1'b1;
			end else begin
				chan_pos = chan_pos + 1'b1;
			end
			res.sample = r[SAMPLE_W-1:0];
			return res;
		endfunction

		function void take_sample(bit start, logic [SAMPLE_W-1:0] raw);
			faded_due.insert(faded_due.size(), fade_sample(start, raw));
		endfunction

		function void match_result(logic [SAMPLE_W-1:0] smp, logic act);
			faded_sample_t want;
			if (faded_due.size() == 0) begin
				$display("%0t: result %h (fade_active %b) with no item waiting",
					$time, smp, act);
				mismatches++;
				return;
			end
			want = faded_due.pop_front();
			matched++;
			if (smp !== want.sample) begin
				$display("%0t: sample_out expected %h, actual %h", $time, want.sample, smp);
				mismatches++;
			end
			if (act !== want.active) begin
				$display("%0t: fade_active expected %b, actual %b", $time, want.active, act);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	alfi_in_if  in_ch();
	alfi_out_if out_ch();

	audio_linear_fade_in #(
		.FADE_FRAMES  (FADE_LEN),
		.MAX_CHANNELS (MAX_CH)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fade_ramp_tracker ramp = new();

	int unsigned cycles = 0;
	int unsigned items_sent;
	int unsigned fades_started;
	int unsigned reg_writes;
	int unsigned burst_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up well past the slowest legal run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_CAP) begin
			$display("%0t: timeout with %0d results outstanding", $time, ramp.waiting());
			$display("Mismatches found");
			$finish;
		end
	end

	// Check every result that leaves the block.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			ramp.match_result(out_ch.sample_out, out_ch.fade_active);
	end

	// Receiver: switch between stall styles every so often, so that stalls
	// land on every stage of the pipeline; one style never stalls at all.
	initial begin
		int unsigned style;
		int unsigned style_left;
		int unsigned tick;
		out_ch.ready = 1'b0;
		style_left   = 0;
		tick         = 0;
		forever begin
			@(negedge clk);
			if (style_left == 0) begin
				style      = $urandom_range(0, 3);
				style_left = $urandom_range(20, 200);
			end
			style_left--;
			tick++;
			case (style)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= 1'($urandom_range(0, 1));
				2: out_ch.ready <= ($urandom_range(0, 3) == 0);
				default: out_ch.ready <= ((tick % 16) < 11);
			endcase
		end
	end

	// Drop valid for a gap; drive junk on the payload meanwhile.
	task automatic idle_sender(input int unsigned n);
		in_ch.valid      <= 1'b0;
		in_ch.start_fade <= 1'($urandom_range(0, 1));
		in_ch.sample_in  <= $urandom;
		repeat (n) @(negedge clk);
	endtask

	// Present one item and hold it until it is taken; called at a falling edge.
	task automatic push_sample(input bit st, input logic [SAMPLE_W-1:0] smp);
		in_ch.valid      <= 1'b1;
		in_ch.start_fade <= st;
		in_ch.sample_in  <= smp;
		do @(posedge clk); while (!in_ch.ready);
		ramp.take_sample(st, smp);
		@(negedge clk);
	endtask

	// Send an item as part of a burst; open a new burst after a random gap.
	task automatic send(input bit st, input logic [SAMPLE_W-1:0] smp);
		int unsigned gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30)
			                                          : $urandom_range(1, 5);
			idle_sender(gap);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
			                                          : $urandom_range(1, 20);
		end
		burst_left--;
		push_sample(st, smp);
		items_sent++;
		if (st)
			fades_started++;
	endtask

	// Hold the sender until every result is back and the pipeline is empty.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (ramp.waiting() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
		@(negedge clk);
		burst_left = 0;
	endtask

	task automatic write_one(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		ramp.set_reg(idx, data);
		reg_writes++;
		@(negedge clk);
	endtask

	// Write both registers, and a spare index now and then; only when idle.
	task automatic write_regs(input logic [CFG_DATA_W-1:0] cnt,
		input logic [CFG_DATA_W-1:0] mode_data, input bit poke_spare);
		write_one(alfi_pkg::CFG_CHANNEL_COUNT, cnt);
		write_one(alfi_pkg::CFG_SAMPLE_WIDTH_MODE, mode_data);
		if (poke_spare)
			write_one($urandom_range(0, 1) ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO,
				4'($urandom_range(0, 15)));
		cfg_we <= 1'b0;
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [SAMPLE_W-1:0] edges [8];
		edges = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_7FFF, 32'hFFFF_8000,
		          32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_00FF};
		case ($urandom_range(0, 7))
			3: return edges[$urandom_range(0, 7)];
			4: return {16'($urandom), ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)};
			5: return SAMPLE_W'($signed($urandom_range(0, 600)) - 300);
			6: return SAMPLE_W'($signed(16'($urandom)));
			default: return $urandom;
		endcase
	endfunction

	// Often start a fade on a phase's first item; now and then restart on a frame boundary or anywhere.
	task automatic run_phase(input int unsigned n_items, input bit force_start,
		input bit pause_mid);
		bit st;
		for (int unsigned i = 0; i < n_items; i++) begin
			if (pause_mid && i == n_items / 2)
				wait_drained();
			st = 1'b0;
			if (i == 0)
				st = force_start || ($urandom_range(0, 9) < 6);
			else if (ramp.position() == 0 && $urandom_range(0, 399) == 0)
				st = 1'b1;
			else if ($urandom_range(0, 199) == 0)
				st = 1'b1;
			send(st, pick_sample());
		end
	endtask

	task automatic random_setting();
		logic [CFG_DATA_W-1:0] cnt;
		int unsigned           r;
		r = $urandom_range(0, 9);
		if (r < 5)
			cnt = 4'($urandom_range(1, 3));
		else if (r < 8)
			cnt = 4'($urandom_range(4, 8));
		else
			cnt = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
		wait_drained();
		write_regs(cnt, 4'($urandom_range(0, 15)), $urandom_range(0, 3) == 0);
	endtask

	initial begin
		int unsigned phase_no;
		int unsigned goal;
		int unsigned n_phase;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		in_ch.valid      = 1'b0;
		in_ch.start_fade = 1'b0;
		in_ch.sample_in  = '0;
		items_sent       = 0;
		fades_started    = 0;
		reg_writes       = 0;
		burst_left       = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: two channels, 16-bit. No fade yet, so pass through;
		// upper bits are ignored in 16-bit mode.
		send(1'b0, 32'h1234_8000);
		send(1'b0, 32'h0000_7FFF);
		// Fade from the first frame: most positive and most negative 16-bit.
		send(1'b1, 32'h0000_7FFF);
		send(1'b0, 32'hFFFF_8000);
		// Small values truncate toward zero, not toward minus infinity.
		send(1'b0, 32'hFFFF_FFFF);
		send(1'b0, 32'hABCD_0001);
		// Restart in the middle of a frame.
		send(1'b0, 32'h0000_03E8);
		send(1'b1, 32'hFFFF_FC18);
		send(1'b0, 32'h0000_7FFF);

		// One channel, 32-bit samples at the extremes.
		wait_drained();
		write_regs(4'd1, 4'd1, 1'b0);
		send(1'b1, 32'h7FFF_FFFF);
		send(1'b0, 32'h8000_0000);
		send(1'b0, 32'hFFFF_FFFF);
		send(1'b0, 32'h0000_0001);

		// A count of zero behaves as one; a spare index is ignored.
		wait_drained();
		write_regs(4'd0, 4'd1, 1'b1);
		send(1'b0, 32'h1234_5678);
		send(1'b1, 32'hFFFF_FFFB);

		// Counts above the maximum clamp to eight; 16-bit with junk upper data bits.
		wait_drained();
		write_regs(4'd15, 4'd14, 1'b0);
		send(1'b1, 32'hFFFF_7FFF);
		for (int i = 0; i < 8; i++)
			send(1'b0, pick_sample());

		// Shrink the frame while mid-frame: the next sample closes it.
		wait_drained();
		write_regs(4'd1, 4'd0, 1'b0);
		send(1'b0, 32'h0000_4000);
		send(1'b0, 32'hFFFF_C000);

		// One long single-channel fade so the ramp reaches unity and beyond.
		wait_drained();
		write_regs($urandom_range(0, 1) ? 4'd1 : 4'd0, 4'($urandom_range(0, 15)), 1'b0);
		run_phase(300, 1'b1, 1'b0);

		goal     = RAND_ITEMS;
		phase_no = 0;
		while (items_sent < goal) begin
			random_setting();
			n_phase = $urandom_range(30, 140);
			if (n_phase > goal - items_sent)
				n_phase = goal - items_sent;
			run_phase(n_phase, 1'b0, phase_no == 2);
			phase_no++;
		end

		wait_drained();
		repeat (2 * PIPE_DEPTH) @(posedge clk);

		$display("Covered %0d samples with %0d fade starts over %0d register writes;",
			items_sent, fades_started, reg_writes);
		$display("checked %0d results across channel counts 0..15 and both widths.",
			ramp.matched);
		if (ramp.mismatches == 0 && ramp.waiting() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### audio_linear_fade_in.f
+incdir+rtl
rtl/alfi_pkg.sv
rtl/alfi_in_if.sv
rtl/alfi_out_if.sv
rtl/audio_linear_fade_in.sv
dv/tb_audio_linear_fade_in.sv
